>>> rtl/mpsc_pkg.sv
`default_nettype none
package mpsc_pkg;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_LANE = 3'd1;
  localparam logic [2:0] OP_CONN = 3'd2;
  localparam logic [2:0] OP_SLOT = 3'd3;
  localparam logic [2:0] OP_SCNT = 3'd4;

  localparam logic [2:0] CFG_MIN_GREEN   = 3'd0;
  localparam logic [2:0] CFG_MAX_GREEN   = 3'd1;
  localparam logic [2:0] CFG_YELLOW      = 3'd2;
  localparam logic [2:0] CFG_STARVATION  = 3'd3;
  localparam logic [2:0] CFG_PHASE_COUNT = 3'd4;

  localparam logic [15:0] RST_MIN_GREEN   = 16'd5000;
  localparam logic [15:0] RST_MAX_GREEN   = 16'd15000;
  localparam logic [15:0] RST_YELLOW      = 16'd3000;
  localparam logic [15:0] RST_STARVATION  = 16'd20000;
  localparam logic [3:0]  RST_PHASE_COUNT = 4'd1;

  typedef enum logic [2:0] {
    CMD_NOP,
    CMD_TICK,
    CMD_LANE,
    CMD_CONN,
    CMD_SLOT,
    CMD_SCNT
  } cmd_e;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] lane_index;
    logic [7:0] cars;
    logic [4:0] connection_index;
    logic [4:0] source_lane;
    logic [4:0] target_lane;
    logic [2:0] phase_index;
    logic [2:0] slot_index;
    logic [3:0] slot_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0] active_phase;
    logic       light_state;
    logic [2:0] pending_phase;
    logic       yellow_started;
    logic       phase_started;
  } out_item_t;

  typedef struct packed {
    cmd_e       kind;
    logic [4:0] lane_index;
    logic [7:0] cars;
    logic [4:0] connection_index;
    logic [4:0] source_lane;
    logic [4:0] target_lane;
    logic [2:0] phase_index;
    logic [2:0] slot_index;
    logic [3:0] slot_count;
  } cmd_t;

  typedef struct packed {
    logic [15:0] min_green_ms;
    logic [15:0] max_green_ms;
    logic [15:0] yellow_ms;
    logic [15:0] starvation_ms;
    logic [3:0]  phase_count;
  } cfg_t;

endpackage
`default_nettype wire

>>> rtl/mpsc_front.sv
`default_nettype none
module mpsc_front import mpsc_pkg::*; #(
  parameter int PHASES      = 8,
  parameter int LANES       = 32,
  parameter int CONNECTIONS = 32,
  parameter int SLOTS       = 8
) (
  input  in_item_t item_i,
  output cmd_t     cmd_o
);

  always_comb begin
    cmd_o.lane_index       = item_i.lane_index;
    cmd_o.cars             = item_i.cars;
    cmd_o.connection_index = item_i.connection_index;
    cmd_o.source_lane      = item_i.source_lane;
    cmd_o.target_lane      = item_i.target_lane;
    cmd_o.phase_index      = item_i.phase_index;
    cmd_o.slot_index       = item_i.slot_index;
    cmd_o.slot_count       = (item_i.slot_count > SLOTS) ? 4'(SLOTS) : item_i.slot_count;
    cmd_o.kind             = CMD_NOP;
    // Writes with an index beyond the tables are dropped here.
    unique case (item_i.opcode)
      OP_TICK: cmd_o.kind = CMD_TICK;
      OP_LANE: if (item_i.lane_index < LANES) cmd_o.kind = CMD_LANE;
      OP_CONN: if (item_i.connection_index < CONNECTIONS) cmd_o.kind = CMD_CONN;
      OP_SLOT: begin
        if (item_i.phase_index < PHASES && item_i.slot_index < SLOTS) cmd_o.kind = CMD_SLOT;
      end
      OP_SCNT: if (item_i.phase_index < PHASES) cmd_o.kind = CMD_SCNT;
      default: cmd_o.kind = CMD_NOP;
    endcase
  end

endmodule
`default_nettype wire

>>> rtl/mpsc_queue.sv
`default_nettype none
module mpsc_queue import mpsc_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output cmd_t cmd_o
);

  cmd_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign cmd_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule
`default_nettype wire

>>> rtl/mpsc_back.sv
`default_nettype none
module mpsc_back import mpsc_pkg::*; #(
  parameter int PHASES      = 8,
  parameter int LANES       = 32,
  parameter int CONNECTIONS = 32,
  parameter int SLOTS       = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cfg_t      cfg_i,
  input  logic      q_valid_i,
  input  cmd_t      q_cmd_i,
  output logic      q_pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  localparam int PIW = (PHASES > 1) ? $clog2(PHASES) : 1;
  localparam int PCW = $clog2(PHASES + 1);
  localparam int KW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SAW = (PHASES * SLOTS > 1) ? $clog2(PHASES * SLOTS) : 1;
  localparam int CIW = (CONNECTIONS > 1) ? $clog2(CONNECTIONS) : 1;
  localparam int LIW = $clog2(LANES);
  localparam int PRW = $clog2(SLOTS * 255 + 1) + 1;

  typedef enum logic [1:0] {S_IDLE, S_WALK, S_EVAL} state_e;

  state_e state_q;
  logic [31:0] now_q, green_q, yellow_q;
  logic        in_yellow_q;
  logic [PIW-1:0] cur_q, nxt_q;
  logic [31:0] last_q [PHASES];
  logic [3:0]  scnt_q [PHASES];
  logic signed [PRW-1:0] press_q [PHASES];

  logic [LANES-1:0]         lane_vld_q;
  logic [CONNECTIONS-1:0]   conn_vld_q;
  logic [PHASES*SLOTS-1:0]  slot_vld_q;
  logic [7:0] lane_mem [LANES];
  logic [9:0] conn_mem [CONNECTIONS];
  logic [4:0] slot_mem [PHASES*SLOTS];

  logic [PCW-1:0] ph_q;
  logic [KW-1:0]  k_q;
  logic           issuing_q;
  logic [1:0]     drain_q;

  logic           sb_use_q, sc_use_q, sd_use_q;
  logic [PIW-1:0] sb_ph_q, sc_ph_q, sd_ph_q;
  logic [4:0]     slot_rd_q;
  logic           slot_rdv_q;
  logic [9:0]     conn_rd_q;
  logic           conn_rdv_q;
  logic           sd_aok_q, sd_bok_q, lane_av_q, lane_bv_q;
  logic [7:0]     lane_a_q, lane_b_q;

  logic           skip_cur_q, st_found_q, mx_found_q;
  logic [PIW-1:0] st_best_q, mx_best_q;
  logic [31:0]    st_wait_q;
  logic signed [PRW-1:0] mx_p_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic [PCW-1:0] cnt_eff;
  logic           out_free;
  logic [31:0]    now_n;
  logic [PIW-1:0] iss_ph;
  logic [SAW-1:0] slot_raddr, slot_waddr;
  logic           iss_use;
  logic [4:0]     slot_c;
  logic           c_ok;
  logic [CIW-1:0] conn_raddr;
  logic [9:0]     conn_e;
  logic           a_ok, b_ok;
  logic [LIW-1:0] lane_ra, lane_rb;
  logic [7:0]     car_a, car_b;
  logic signed [PRW-1:0] diff;
  logic [PIW-1:0] ev_i;
  logic signed [PRW-1:0] ev_p;
  logic [31:0]    ev_wait;
  logic           st_hit, mx_hit, ev_done;
  logic [PIW-1:0] best;
  logic           lane_we, conn_we, slot_we;

  assign cnt_eff  = (cfg_i.phase_count > PHASES) ? PCW'(PHASES) : PCW'(cfg_i.phase_count);
  assign out_free = !out_valid_q || !out_stall_i;
  assign now_n    = now_q + 32'd1;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i && out_free;

  assign lane_we    = q_pop_o && (q_cmd_i.kind == CMD_LANE);
  assign conn_we    = q_pop_o && (q_cmd_i.kind == CMD_CONN);
  assign slot_we    = q_pop_o && (q_cmd_i.kind == CMD_SLOT);
  assign slot_waddr = SAW'(q_cmd_i.phase_index * SLOTS + q_cmd_i.slot_index);

  // Pressure walk: slot table, connection table and lane table are read in
  // successive stages, one slot issued per cycle.
  assign iss_ph     = ph_q[PIW-1:0];
  assign slot_raddr = SAW'(iss_ph * SLOTS + k_q);
  assign iss_use    = (state_q == S_WALK) && issuing_q && (k_q < scnt_q[iss_ph]);

  assign slot_c     = slot_rdv_q ? slot_rd_q : 5'd0;
  assign c_ok       = slot_c < CONNECTIONS;
  assign conn_raddr = CIW'(slot_c);

  assign conn_e  = conn_rdv_q ? conn_rd_q : 10'd0;
  assign a_ok    = conn_e[9:5] < LANES;
  assign b_ok    = conn_e[4:0] < LANES;
  assign lane_ra = LIW'(conn_e[9:5]);
  assign lane_rb = LIW'(conn_e[4:0]);

  assign car_a = (sd_aok_q && lane_av_q) ? lane_a_q : 8'd0;
  assign car_b = (sd_bok_q && lane_bv_q) ? lane_b_q : 8'd0;
  assign diff  = PRW'($signed({1'b0, car_a})) - PRW'($signed({1'b0, car_b}));

  // The starvation and maximum-pressure searches share one pass over phases.
  assign ev_i    = ph_q[PIW-1:0];
  assign ev_p    = press_q[ev_i];
  assign ev_wait = now_q - last_q[ev_i];
  assign st_hit  = (ev_i != cur_q) && (ev_p > 0) &&
                   (ev_wait > {16'd0, cfg_i.starvation_ms}) && (ev_wait > st_wait_q);
  assign mx_hit  = !(skip_cur_q && ev_i == cur_q) && (!mx_found_q || ev_p > mx_p_q);
  assign ev_done = (ph_q == cnt_eff);
  assign best    = st_found_q ? st_best_q : (mx_found_q ? mx_best_q : cur_q);

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (lane_we) lane_mem[LIW'(q_cmd_i.lane_index)] <= q_cmd_i.cars;
    if (conn_we) conn_mem[CIW'(q_cmd_i.connection_index)] <=
      {q_cmd_i.source_lane, q_cmd_i.target_lane};
    if (slot_we) slot_mem[slot_waddr] <= q_cmd_i.connection_index;
    slot_rd_q <= slot_mem[slot_raddr];
    conn_rd_q <= conn_mem[conn_raddr];
    lane_a_q  <= lane_mem[lane_ra];
    lane_b_q  <= lane_mem[lane_rb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      now_q       <= '0;
      green_q     <= '0;
      yellow_q    <= '0;
      in_yellow_q <= 1'b0;
      cur_q       <= '0;
      nxt_q       <= '0;
      for (int i = 0; i < PHASES; i++) begin
        last_q[i]  <= '0;
        scnt_q[i]  <= '0;
        press_q[i] <= '0;
      end
      lane_vld_q  <= '0;
      conn_vld_q  <= '0;
      slot_vld_q  <= '0;
      ph_q        <= '0;
      k_q         <= '0;
      issuing_q   <= 1'b0;
      drain_q     <= '0;
      sb_use_q    <= 1'b0;
      sc_use_q    <= 1'b0;
      sd_use_q    <= 1'b0;
      sb_ph_q     <= '0;
      sc_ph_q     <= '0;
      sd_ph_q     <= '0;
      slot_rdv_q  <= 1'b0;
      conn_rdv_q  <= 1'b0;
      sd_aok_q    <= 1'b0;
      sd_bok_q    <= 1'b0;
      lane_av_q   <= 1'b0;
      lane_bv_q   <= 1'b0;
      skip_cur_q  <= 1'b0;
      st_found_q  <= 1'b0;
      mx_found_q  <= 1'b0;
      st_best_q   <= '0;
      mx_best_q   <= '0;
      st_wait_q   <= '0;
      mx_p_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      sb_use_q   <= iss_use;
      sb_ph_q    <= iss_ph;
      slot_rdv_q <= slot_vld_q[slot_raddr];
      sc_use_q   <= sb_use_q && c_ok;
      sc_ph_q    <= sb_ph_q;
      conn_rdv_q <= conn_vld_q[conn_raddr];
      sd_use_q   <= sc_use_q;
      sd_ph_q    <= sc_ph_q;
      sd_aok_q   <= a_ok;
      sd_bok_q   <= b_ok;
      lane_av_q  <= lane_vld_q[lane_ra];
      lane_bv_q  <= lane_vld_q[lane_rb];
      if (sd_use_q) press_q[sd_ph_q] <= press_q[sd_ph_q] + diff;

      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;

      unique case (state_q)
        S_IDLE: begin
          if (q_valid_i && out_free) begin
            out_valid_q <= 1'b1;
            out_q <= '{active_phase: 3'(cur_q), light_state: in_yellow_q,
                       pending_phase: 3'(nxt_q), yellow_started: 1'b0,
                       phase_started: 1'b0};
            unique case (q_cmd_i.kind)
              CMD_TICK: begin
                now_q <= now_n;
                if (in_yellow_q) begin
                  if (now_n - yellow_q > {16'd0, cfg_i.yellow_ms}) begin
                    cur_q         <= nxt_q;
                    in_yellow_q   <= 1'b0;
                    green_q       <= now_n;
                    last_q[nxt_q] <= now_n;
                    out_q <= '{active_phase: 3'(nxt_q), light_state: 1'b0,
                               pending_phase: 3'(nxt_q), yellow_started: 1'b0,
                               phase_started: 1'b1};
                  end
                end else if (now_n - green_q > {16'd0, cfg_i.min_green_ms}) begin
                  // The result waits for the decision.
                  out_valid_q <= 1'b0;
                  state_q     <= S_WALK;
                  ph_q        <= '0;
                  k_q         <= '0;
                  issuing_q   <= (cnt_eff != '0);
                  drain_q     <= '0;
                  skip_cur_q  <= (now_n - green_q) > {16'd0, cfg_i.max_green_ms};
                  for (int i = 0; i < PHASES; i++) press_q[i] <= '0;
                end
              end
              CMD_LANE: lane_vld_q[LIW'(q_cmd_i.lane_index)] <= 1'b1;
              CMD_CONN: conn_vld_q[CIW'(q_cmd_i.connection_index)] <= 1'b1;
              CMD_SLOT: slot_vld_q[slot_waddr] <= 1'b1;
              CMD_SCNT: scnt_q[PIW'(q_cmd_i.phase_index)] <= q_cmd_i.slot_count;
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (issuing_q) begin
            if (k_q == KW'(SLOTS - 1)) begin
              k_q  <= '0;
              ph_q <= ph_q + PCW'(1);
              if (ph_q + PCW'(1) == cnt_eff) issuing_q <= 1'b0;
            end else begin
              k_q <= k_q + KW'(1);
            end
          end else if (drain_q == 2'd2) begin
            state_q    <= S_EVAL;
            ph_q       <= '0;
            st_found_q <= 1'b0;
            st_wait_q  <= '0;
            mx_found_q <= 1'b0;
          end else begin
            drain_q <= drain_q + 2'd1;
          end
        end
        S_EVAL: begin
          if (!ev_done) begin
            if (st_hit) begin
              st_found_q <= 1'b1;
              st_best_q  <= ev_i;
              st_wait_q  <= ev_wait;
            end
            if (mx_hit) begin
              mx_found_q <= 1'b1;
              mx_best_q  <= ev_i;
              mx_p_q     <= ev_p;
            end
            ph_q <= ph_q + PCW'(1);
          end else if (out_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
            if (best != cur_q) begin
              nxt_q       <= best;
              in_yellow_q <= 1'b1;
              yellow_q    <= now_q;
              out_q <= '{active_phase: 3'(cur_q), light_state: 1'b1,
                         pending_phase: 3'(best), yellow_started: 1'b1,
                         phase_started: 1'b0};
            end else begin
              out_q <= '{active_phase: 3'(cur_q), light_state: in_yellow_q,
                         pending_phase: 3'(nxt_q), yellow_started: 1'b0,
                         phase_started: 1'b0};
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/max_pressure_signal_phase_controller.sv
// Flow: a table write or a tick without a decision passes the input queue and then the output
// register; a deciding tick first runs the pressure walk and then the phase search.
// Throughput: one transaction per cycle in the back end while the output is not stalled, except that
// a deciding tick holds it for the length of the pressure walk and phase search.
// Reset: timers, phase state and registers to their defaults; tables read as zero
// through per-entry valid bits, so no clearing pass is needed.
`default_nettype none
module max_pressure_signal_phase_controller import mpsc_pkg::*; #(
  parameter int PHASES      = 8,
  parameter int LANES       = 32,
  parameter int CONNECTIONS = 32,
  parameter int SLOTS       = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_addr_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o
);

  cfg_t cfg_q;
  cmd_t front_cmd, q_cmd;
  logic q_full, q_push, q_pop, q_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{min_green_ms: RST_MIN_GREEN, max_green_ms: RST_MAX_GREEN,
                 yellow_ms: RST_YELLOW, starvation_ms: RST_STARVATION,
                 phase_count: RST_PHASE_COUNT};
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_MIN_GREEN:   cfg_q.min_green_ms  <= cfg_wdata_i;
        CFG_MAX_GREEN:   cfg_q.max_green_ms  <= cfg_wdata_i;
        CFG_YELLOW:      cfg_q.yellow_ms     <= cfg_wdata_i;
        CFG_STARVATION:  cfg_q.starvation_ms <= cfg_wdata_i;
        CFG_PHASE_COUNT: cfg_q.phase_count   <= cfg_wdata_i[3:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  mpsc_front #(
    .PHASES(PHASES), .LANES(LANES), .CONNECTIONS(CONNECTIONS), .SLOTS(SLOTS)
  ) u_front (
    .item_i(in_data_i),
    .cmd_o (front_cmd)
  );

  mpsc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .cmd_i  (front_cmd),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .cmd_o  (q_cmd)
  );

  mpsc_back #(
    .PHASES(PHASES), .LANES(LANES), .CONNECTIONS(CONNECTIONS), .SLOTS(SLOTS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_cmd),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

`ifndef SYNTHESIS
  a_pop_needs_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_yellow_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.yellow_started |-> out_data_o.light_state &&
      !out_data_o.phase_started) else $error("yellow start without yellow light");

  a_phase_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.phase_started |-> !out_data_o.light_state &&
      out_data_o.active_phase == out_data_o.pending_phase)
    else $error("phase start inconsistent with status");

  a_yellow_changes_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.yellow_started |->
      (PHASES > 8) || (out_data_o.pending_phase != out_data_o.active_phase))
    else $error("yellow started towards the current phase");
`endif

endmodule
`default_nettype wire
